@@ sv/sis_pkg.sv @@
`default_nettype none

package sis_pkg;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;      // place the incoming item this cycle
        logic drain;       // move every entry one cell toward the head
        logic descending;  // sort direction for this insertion
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sis_cell.sv @@
`default_nettype none

module sis_cell #(
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16
) (
    input  wire                     clk,
    input  sis_pkg::cell_ctrl_t     ctrl,
    input  wire  [KEY_BITS-1:0]     new_key,
    input  wire  [TAG_BITS-1:0]     new_tag,
    input  wire                     occupied,   // cell holds a stored item
    input  wire                     at_end,     // first free cell of the chain
    input  wire                     prev_shift, // neighbor toward the head moves up
    input  wire  [KEY_BITS-1:0]     prev_key,
    input  wire  [TAG_BITS-1:0]     prev_tag,
    input  wire  [KEY_BITS-1:0]     next_key,
    input  wire  [TAG_BITS-1:0]     next_tag,
    input  wire                     next_follow, // every entry behind this one moves up
    output logic [KEY_BITS-1:0]     key,
    output logic [TAG_BITS-1:0]     tag,
    output logic                    follow,     // this entry and all behind it move up
    output logic                    shift       // this entry moves one cell away
);
    import sis_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;
    logic                goes_before;

    // Strict compare keeps equal keys in arrival order
    assign goes_before = ctrl.descending ? (new_key > key_reg) : (new_key < key_reg);
    // Scan stops at the first entry from the tail that does not follow the new item,
    // so entries stored under the other direction are never reordered
    assign follow      = !occupied || (goes_before && next_follow);
    assign shift       = occupied && follow;

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.drain)
        begin
            key_next = next_key;
            tag_next = next_tag;
        end
        else if (ctrl.insert && prev_shift)
        begin
            key_next = prev_key;
            tag_next = prev_tag;
        end
        else if (ctrl.insert && (shift || at_end))
        begin
            key_next = new_key;
            tag_next = new_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

@@ sv/stable_insertion_sorter_core.sv @@
`default_nettype none
// Channel  | Handshake         | Payload
// s_*      | s_tvalid/s_tready | s_tdata = {tag, key}, s_tlast = final item of the set
// m_*      | m_tvalid/m_tready | m_tdata = {sorted_tag, sorted_key}, m_tlast = end of run,
//          |                   | m_tuser = dropped
// cfg_*    | cfg_we            | cfg_wdata = descending
//
// Every cell compares each input item in parallel and the chain shifts once.
// After the final item the store drains one item per cycle from the head cell while
// m_tready is high, and no input is taken during that drain.
// Reset clears the fill count, the drop flag, the drain state and the direction.
// Output stalls hold the head cell and the whole chain in place.

module stable_insertion_sorter_core #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16
) (
    input  wire                                             clk,
    input  wire                                             rst_n,
    // s_tdata: key, tag (from bit 0 up), zero padded to bytes
    input  wire  [((KEY_BITS+TAG_BITS+7)/8)*8-1:0]          s_tdata,
    input  wire                                             s_tlast,
    input  wire                                             s_tvalid,
    output logic                                            s_tready,
    // m_tdata: sorted_key, sorted_tag (from bit 0 up), zero padded to bytes
    output logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0]          m_tdata,
    // m_tuser: dropped
    output logic                                            m_tuser,
    output logic                                            m_tlast,
    output logic                                            m_tvalid,
    input  wire                                             m_tready,
    input  wire                                             cfg_we,
    input  wire                                             cfg_wdata
);
    import sis_pkg::*;

    localparam int DATA_W = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int PAD_W  = DATA_W - KEY_BITS - TAG_BITS;
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(CAPACITY);
    localparam logic [FILL_W-1:0] ONE        = FILL_W'(1);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              overflow_reg;
    logic              overflow_next;
    logic              draining_reg;
    logic              draining_next;
    logic              descending_reg;

    logic              in_fire;
    logic              out_fire;
    logic              full;
    cell_ctrl_t        ctrl;

    logic [KEY_BITS-1:0] new_key;
    logic [TAG_BITS-1:0] new_tag;

    logic [KEY_BITS-1:0] cell_key    [CAPACITY];
    logic [TAG_BITS-1:0] cell_tag    [CAPACITY];
    logic                cell_shift  [CAPACITY];
    logic                cell_follow [CAPACITY];

    assign new_key  = s_tdata[KEY_BITS-1:0];
    assign new_tag  = s_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS];

    // Take items until the final one, then hold input off for the drain
    assign s_tready = !draining_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign full     = (fill_reg == FULL_COUNT);

    assign ctrl.insert     = in_fire && !full;
    assign ctrl.drain      = out_fire;
    assign ctrl.descending = descending_reg;

    // Row of compare-and-shift cells; cell 0 is the head of the sorted order
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [FILL_W-1:0] IDX = FILL_W'(i);

        logic                prev_shift;
        logic [KEY_BITS-1:0] prev_key;
        logic [TAG_BITS-1:0] prev_tag;
        logic [KEY_BITS-1:0] next_key;
        logic [TAG_BITS-1:0] next_tag;
        logic                next_follow;

        if (i == 0)
        begin : g_head
            assign prev_shift = 1'b0;
            assign prev_key   = new_key;
            assign prev_tag   = new_tag;
        end
        else
        begin : g_body
            assign prev_shift = cell_shift[i-1];
            assign prev_key   = cell_key[i-1];
            assign prev_tag   = cell_tag[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            // Nothing behind the last cell; its content past the fill is unused
            assign next_key    = cell_key[i];
            assign next_tag    = cell_tag[i];
            assign next_follow = 1'b1;
        end
        else
        begin : g_mid
            assign next_key    = cell_key[i+1];
            assign next_tag    = cell_tag[i+1];
            assign next_follow = cell_follow[i+1];
        end

        sis_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_key     (new_key),
            .new_tag     (new_tag),
            .occupied    (IDX < fill_reg),
            .at_end      (IDX == fill_reg),
            .prev_shift  (prev_shift),
            .prev_key    (prev_key),
            .prev_tag    (prev_tag),
            .next_key    (next_key),
            .next_tag    (next_tag),
            .next_follow (next_follow),
            .key         (cell_key[i]),
            .tag         (cell_tag[i]),
            .follow      (cell_follow[i]),
            .shift       (cell_shift[i])
        );
    end

    // Fill count, drop flag and drain state
    always_comb
    begin
        fill_next     = fill_reg;
        overflow_next = overflow_reg;
        draining_next = draining_reg;
        if (in_fire)
        begin
            if (full)
                overflow_next = 1'b1;   // drop the item, remember it for the run
            else
                fill_next = fill_reg + ONE;
            if (s_tlast)
                draining_next = 1'b1;
        end
        if (out_fire)
        begin
            fill_next = fill_reg - ONE;
            if (fill_reg == ONE)
            begin
                // last result taken: clear the set
                draining_next = 1'b0;
                overflow_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            overflow_reg   <= 1'b0;
            draining_reg   <= 1'b0;
            descending_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            overflow_reg <= overflow_next;
            draining_reg <= draining_next;
            if (cfg_we)
                descending_reg <= cfg_wdata;
        end
    end

    // Present the head cell while draining
    assign m_tvalid = draining_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, cell_tag[0], cell_key[0]};
    assign m_tlast  = (fill_reg == ONE);
    assign m_tuser  = overflow_reg;

`ifndef SYNTHESIS
    a_drain_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> (fill_reg != '0))
        else $error("drain with empty store");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_COUNT)
        else $error("fill count beyond capacity");

    a_sides_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input open during drain");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && m_tlast) |=> (!m_tvalid && (fill_reg == '0) && !overflow_reg))
        else $error("run did not end cleanly");

    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !m_tlast) |=> (fill_reg == $past(fill_reg) - ONE))
        else $error("drain did not advance");
`endif

endmodule

`default_nettype wire
